### rtl/stpr_pkg.sv
// Shared types and constants for the trapezoidal stepper ramp block.
// Used by the divider, datapath, controller and top level.
package stpr_pkg;

   localparam int CORE_CLOCK_HZ  = 168000000;
   localparam int STEP_BITS      = 24;
   localparam int SPEED_BITS     = 16;
   localparam int PERIOD_BITS    = 27;
   localparam int COMPARE_BITS   = 26;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIV_CNT_BITS   = $clog2(PERIOD_BITS + 1);

   localparam logic [PERIOD_BITS-1:0] HALF_CLOCK = PERIOD_BITS'(CORE_CLOCK_HZ / 2);

   // floor(x/10) == (x * 52429) >> 19 for every 16-bit x
   localparam int                 TEN_RECIP_BITS = 17;
   localparam logic [TEN_RECIP_BITS-1:0] TEN_RECIP = 17'd52429;
   localparam int                 TEN_SHIFT      = 19;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_PULSE = 2'd2;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_ACCEL  = 2'd1;
   localparam logic [1:0] PH_CRUISE = 2'd2;
   localparam logic [1:0] PH_DECEL  = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_SPEED = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_SPEED   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL_MS    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECEL_MS    = 2'd3;

   localparam logic [1:0] SEL_ACCEL  = 2'd0;
   localparam logic [1:0] SEL_DECEL  = 2'd1;
   localparam logic [1:0] SEL_PERIOD = 2'd2;

   typedef struct packed {
      logic       latch_req;
      logic       div_go;
      logic [1:0] div_sel;
      logic       save_inc;
      logic       apply;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_start;
      logic div_busy;
      logic div_done;
      logic out_blocked;
   } dp_status_type;

endpackage

### rtl/stpr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stpr_pkg for widths.
module stpr_div
   import stpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [PERIOD_BITS-1:0] dividend,
   input  logic [SPEED_BITS-1:0]  divisor,
   output logic                   busy,
   output logic                   done,
   output logic [PERIOD_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PERIOD_BITS-1:0]  quo_ff, quo_in;
   logic [SPEED_BITS-1:0]   rem_ff, rem_in;
   logic [SPEED_BITS-1:0]   dsr_ff, dsr_in;
   logic [SPEED_BITS:0]     trial;
   logic [SPEED_BITS:0]     diff;

   assign trial = {rem_ff, quo_ff[PERIOD_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(PERIOD_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[SPEED_BITS-1:0];
            quo_in = {quo_ff[PERIOD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SPEED_BITS-1:0];
            quo_in = {quo_ff[PERIOD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");
`endif

endmodule

### rtl/stpr_dp.sv
// Datapath: config registers, move state, ramp update and output register.
// Depends on stpr_pkg and stpr_div.
module stpr_dp
   import stpr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic [1:0]                req_type,
   input  logic [STEP_BITS-1:0]      req_move_steps,
   input  logic                      req_move_forward,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SPEED_BITS-1:0]     csr_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic                      rsp_pulse_on,
   output logic [PERIOD_BITS-1:0]    rsp_pulse_period,
   output logic [COMPARE_BITS-1:0]   rsp_pulse_compare,
   output logic                      rsp_dir_level,
   output logic                      rsp_enable_low,
   output logic                      rsp_move_busy,
   output logic                      rsp_move_done
);

   logic [SPEED_BITS-1:0] start_ff, top_ff, accel_ff, decel_ff;

   logic [1:0]            rtype_ff;
   logic [STEP_BITS-1:0]  rsteps_ff;
   logic                  rfwd_ff;
   logic [SPEED_BITS-1:0] inc_a_ff;

   logic [1:0]            phase_ff, phase_in;
   logic [SPEED_BITS-1:0] speed_ff, speed_in;
   logic [STEP_BITS-1:0]  taken_ff, taken_in;
   logic [STEP_BITS-1:0]  wanted_ff, wanted_in;
   logic [SPEED_BITS-1:0] up_ff, up_in;
   logic [SPEED_BITS-1:0] dn_ff, dn_in;
   logic                  dir_ff, dir_in;
   logic                  done_ff, done_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_on_ff;
   logic [PERIOD_BITS-1:0]  out_period_ff;
   logic                    out_dir_ff;
   logic                    out_done_ff;

   // divider operand selection
   logic [SPEED_BITS-1:0]                time_sel;
   logic [SPEED_BITS+TEN_RECIP_BITS-1:0] ticks_prod;
   logic [SPEED_BITS-1:0]                ticks_raw;
   logic [SPEED_BITS-1:0]                ticks;
   logic [SPEED_BITS-1:0]                speed_diff;
   logic [PERIOD_BITS-1:0]               div_dividend;
   logic [SPEED_BITS-1:0]                div_divisor;
   logic                                 div_busy, div_done;
   logic [PERIOD_BITS-1:0]               div_quot;
   logic [SPEED_BITS-1:0]                inc_now;

   assign time_sel   = (cmd.div_sel == SEL_ACCEL) ? accel_ff : decel_ff;
   assign ticks_prod = time_sel * TEN_RECIP;
   assign ticks_raw  = SPEED_BITS'(ticks_prod >> TEN_SHIFT);
   assign ticks      = (ticks_raw == '0) ? SPEED_BITS'(1) : ticks_raw;
   assign speed_diff = (top_ff > start_ff) ? (top_ff - start_ff) : '0;

   always_comb begin
      if (cmd.div_sel == SEL_PERIOD) begin
         div_dividend = HALF_CLOCK;
         div_divisor  = speed_ff;
      end else begin
         div_dividend = PERIOD_BITS'(speed_diff);
         div_divisor  = ticks;
      end
   end

   stpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign inc_now = (div_quot[SPEED_BITS-1:0] == '0) ? SPEED_BITS'(1)
                                                     : div_quot[SPEED_BITS-1:0];

   // move state update
   logic                  go_cruise, go_leave, go_stop;
   logic [SPEED_BITS:0]   speed_up;
   logic [STEP_BITS-1:0]  taken_inc;

   assign speed_up  = {1'b0, speed_ff} + {1'b0, up_ff};
   assign taken_inc = (taken_ff != '1) ? (taken_ff + 1'b1) : taken_ff;

   always_comb begin
      phase_in  = phase_ff;
      speed_in  = speed_ff;
      taken_in  = taken_ff;
      wanted_in = wanted_ff;
      up_in     = up_ff;
      dn_in     = dn_ff;
      dir_in    = dir_ff;
      done_in   = 1'b0;
      go_cruise = 1'b0;
      go_leave  = 1'b0;
      go_stop   = 1'b0;
      unique case (rtype_ff)
         REQ_START: begin
            wanted_in = rsteps_ff;
            taken_in  = '0;
            dir_in    = rfwd_ff;
            up_in     = inc_a_ff;
            dn_in     = inc_now;
            if (start_ff <= top_ff) begin
               phase_in = PH_ACCEL;
               speed_in = start_ff;
            end else begin
               go_cruise = 1'b1;
            end
         end
         REQ_TICK: begin
            if (phase_ff == PH_ACCEL) begin
               if (taken_ff >= (wanted_ff >> 1)) begin
                  go_cruise = 1'b1;
               end else if (speed_up > {1'b0, top_ff}) begin
                  go_cruise = 1'b1;
               end else begin
                  speed_in = speed_up[SPEED_BITS-1:0];
               end
            end else if (phase_ff == PH_DECEL) begin
               if (taken_ff >= wanted_ff) begin
                  go_stop = 1'b1;
               end else if (dn_ff > speed_ff || (speed_ff - dn_ff) < start_ff) begin
                  go_stop = 1'b1;
               end else begin
                  speed_in = speed_ff - dn_ff;
               end
            end
         end
         REQ_PULSE: begin
            if (phase_ff != PH_IDLE) begin
               taken_in = taken_inc;
               if (phase_ff == PH_CRUISE && taken_inc >= (wanted_ff >> 1)) begin
                  go_leave = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (go_cruise) begin
         phase_in = PH_CRUISE;
         speed_in = top_ff;
         if (taken_in >= (wanted_in >> 1)) begin
            go_leave = 1'b1;
         end
      end
      if (go_leave) begin
         if (top_ff >= start_ff) begin
            phase_in = PH_DECEL;
            speed_in = top_ff;
         end else begin
            go_stop = 1'b1;
         end
      end
      if (go_stop) begin
         phase_in = PH_IDLE;
         speed_in = '0;
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= SPEED_BITS'(200);
         top_ff    <= SPEED_BITS'(800);
         accel_ff  <= SPEED_BITS'(1000);
         decel_ff  <= SPEED_BITS'(1000);
         phase_ff  <= PH_IDLE;
         speed_ff  <= '0;
         taken_ff  <= '0;
         wanted_ff <= '0;
         up_ff     <= '0;
         dn_ff     <= '0;
         dir_ff    <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_START_SPEED: start_ff <= csr_data;
               CSR_TOP_SPEED:   top_ff   <= csr_data;
               CSR_ACCEL_MS:    accel_ff <= csr_data;
               CSR_DECEL_MS:    decel_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.apply) begin
            phase_ff  <= phase_in;
            speed_ff  <= speed_in;
            taken_ff  <= taken_in;
            wanted_ff <= wanted_in;
            up_ff     <= up_in;
            dn_ff     <= dn_in;
            dir_ff    <= dir_in;
            done_ff   <= done_in;
         end
      end
      if (cmd.latch_req) begin
         rtype_ff  <= req_type;
         rsteps_ff <= req_move_steps;
         rfwd_ff   <= req_move_forward;
      end
      if (cmd.save_inc) begin
         inc_a_ff <= inc_now;
      end
   end

   // output register
   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_out) begin
         out_on_ff     <= (phase_ff != PH_IDLE);
         out_period_ff <= (phase_ff != PH_IDLE && speed_ff != '0) ? div_quot : '0;
         out_dir_ff    <= dir_ff;
         out_done_ff   <= done_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_on      = out_on_ff;
   assign rsp_pulse_period  = out_period_ff;
   assign rsp_pulse_compare = out_period_ff[PERIOD_BITS-1:1];
   assign rsp_dir_level     = out_dir_ff;
   assign rsp_enable_low    = ~out_on_ff;
   assign rsp_move_busy     = out_on_ff;
   assign rsp_move_done     = out_done_ff;

   assign status.req_start   = (rtype_ff == REQ_START);
   assign status.div_busy    = div_busy;
   assign status.div_done    = div_done;
   assign status.out_blocked = rsp_valid_ff & rsp_stall;

`ifndef SYNTH
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded word not presented");
   a_idle_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_on_ff |-> out_period_ff == '0)
      else $error("stopped word carries a period");
`endif

endmodule

### rtl/stpr_ctrl.sv
// Controller: sequences request latch, increment divides, update, period divide and output load.
// Depends on stpr_pkg.
module stpr_ctrl
   import stpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LAUNCH_A = 3'd1;
   localparam logic [2:0] ST_WAIT_A   = 3'd2;
   localparam logic [2:0] ST_WAIT_D   = 3'd3;
   localparam logic [2:0] ST_APPLY    = 3'd4;
   localparam logic [2:0] ST_LAUNCH_P = 3'd5;
   localparam logic [2:0] ST_WAIT_P   = 3'd6;
   localparam logic [2:0] ST_OUT      = 3'd7;

   logic [2:0] st_ff, st_in;

   assign req_stall = (st_ff != ST_IDLE);

   always_comb begin
      st_in         = st_ff;
      cmd.latch_req = 1'b0;
      cmd.div_go    = 1'b0;
      cmd.div_sel   = SEL_PERIOD;
      cmd.save_inc  = 1'b0;
      cmd.apply     = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               st_in         = ST_LAUNCH_A;
            end
         end
         ST_LAUNCH_A: begin
            if (status.req_start) begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = SEL_ACCEL;
               st_in       = ST_WAIT_A;
            end else begin
               st_in = ST_APPLY;
            end
         end
         ST_WAIT_A: begin
            cmd.div_sel = SEL_DECEL;
            if (status.div_done) begin
               cmd.save_inc = 1'b1;
               cmd.div_go   = 1'b1;
               st_in        = ST_WAIT_D;
            end
         end
         ST_WAIT_D: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               st_in     = ST_LAUNCH_P;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            st_in     = ST_LAUNCH_P;
         end
         ST_LAUNCH_P: begin
            cmd.div_go = 1'b1;
            st_in      = ST_WAIT_P;
         end
         ST_WAIT_P: begin
            if (status.div_done) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_blocked) begin
               cmd.load_out = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

`ifndef SYNTH
   a_go_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !status.div_busy)
      else $error("divider started while running");
`endif

endmodule

### rtl/stepper_trapezoid_ramp.sv
// Top level of the trapezoidal stepper ramp sequencer.
// Depends on stpr_pkg, stpr_ctrl and stpr_dp.
//
// Usage:
//   req_ channel: one word per event; req_type selects start move, 10 ms
//   ramp tick or step-pulse done. move_steps/move_forward matter on start.
//   rsp_ channel: exactly one word per request with the timer period
//   (half clock / speed), 50% compare, direction, enable and status.
//   csr_ channel: register index 0..3 (start speed, top speed, accel ms,
//   decel ms) and 16-bit data; always ready, write only while idle.
// Timing:
//   Everything runs through one 27-iteration serial divider. A start word
//   takes three divides (two ramp increments and the period); tick and
//   pulse words take one divide (the period). One word is in work at a time:
//   the next word is accepted the cycle after the result is loaded.
// Reset: registers return to 200/800/1000/1000 steps/s and ms, move idle.
// Stall: a finished word waits in the output register; the next request is
//   accepted and worked on, and holds only at its own result.
module stepper_trapezoid_ramp
   import stpr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [STEP_BITS-1:0]      req_move_steps,
   input  logic                      req_move_forward,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_pulse_on,
   output logic [PERIOD_BITS-1:0]    rsp_pulse_period,
   output logic [COMPARE_BITS-1:0]   rsp_pulse_compare,
   output logic                      rsp_dir_level,
   output logic                      rsp_enable_low,
   output logic                      rsp_move_busy,
   output logic                      rsp_move_done,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SPEED_BITS-1:0]     csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   stpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stpr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_move_steps    (req_move_steps),
      .req_move_forward  (req_move_forward),
      .csr_write         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_pulse_on      (rsp_pulse_on),
      .rsp_pulse_period  (rsp_pulse_period),
      .rsp_pulse_compare (rsp_pulse_compare),
      .rsp_dir_level     (rsp_dir_level),
      .rsp_enable_low    (rsp_enable_low),
      .rsp_move_busy     (rsp_move_busy),
      .rsp_move_done     (rsp_move_done)
   );

endmodule

### test/stepper_trapezoid_ramp_tb.sv
// Self-checking testbench for stepper_trapezoid_ramp: directed table, then random moves.
// Every rsp word is compared with a local model of the ramp sequencer or a fixed table word.
// Depends on stpr_pkg and the stepper_trapezoid_ramp RTL only.
module stepper_trapezoid_ramp_tb;
   import stpr_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int TARGET_ITEMS = 950;
   localparam int PHASE_ITEMS  = 80;
   localparam int MOVE_ITEMS   = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;
   localparam int CYCLE_LIMIT  = 800000;

   typedef struct packed {
      logic                    pulse_on;
      logic [PERIOD_BITS-1:0]  period;
      logic [COMPARE_BITS-1:0] compare;
      logic                    dir_level;
      logic                    enable_low;
      logic                    busy;
      logic                    done;
   } ramp_word_type;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [1:0]           code;
      logic [STEP_BITS-1:0] value;
      logic                 fwd;
      logic                 typed;
      ramp_word_type        want;
   } plan_row_type;

   localparam ramp_word_type IDLE_WORD = '{1'b0, 27'd0, 26'd0, 1'b0, 1'b1, 1'b0, 1'b0};
   localparam ramp_word_type DONE_FWD = '{1'b0, 27'd0, 26'd0, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam ramp_word_type DONE_BWD = '{1'b0, 27'd0, 26'd0, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam ramp_word_type RESET_RUN = '{1'b1, 27'd420000, 26'd210000, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam ramp_word_type SLOW_FWD = '{1'b1, 27'd84000000, 26'd42000000, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam ramp_word_type SLOW_BWD = '{1'b1, 27'd84000000, 26'd42000000, 1'b0, 1'b0, 1'b1, 1'b0};
   localparam ramp_word_type FAST_FWD = '{1'b1, 27'd1281, 26'd640, 1'b1, 1'b0, 1'b1, 1'b0};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type = REQ_TICK;
   logic [STEP_BITS-1:0]      req_move_steps = '0;
   logic                      req_move_forward = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_pulse_on;
   logic [PERIOD_BITS-1:0]    rsp_pulse_period;
   logic [COMPARE_BITS-1:0]   rsp_pulse_compare;
   logic                      rsp_dir_level;
   logic                      rsp_enable_low;
   logic                      rsp_move_busy;
   logic                      rsp_move_done;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_START_SPEED;
   logic [SPEED_BITS-1:0]     csr_data = '0;

   stepper_trapezoid_ramp dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_move_steps    (req_move_steps),
      .req_move_forward  (req_move_forward),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pulse_on      (rsp_pulse_on),
      .rsp_pulse_period  (rsp_pulse_period),
      .rsp_pulse_compare (rsp_pulse_compare),
      .rsp_dir_level     (rsp_dir_level),
      .rsp_enable_low    (rsp_enable_low),
      .rsp_move_busy     (rsp_move_busy),
      .rsp_move_done     (rsp_move_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // model state and live registers
   logic [SPEED_BITS-1:0] cfg_start = 16'd200;
   logic [SPEED_BITS-1:0] cfg_top = 16'd800;
   logic [SPEED_BITS-1:0] cfg_accel_ms = 16'd1000;
   logic [SPEED_BITS-1:0] cfg_decel_ms = 16'd1000;
   logic [1:0]            ramp_ph = PH_IDLE;
   logic [SPEED_BITS-1:0] speed_now = '0;
   logic [SPEED_BITS-1:0] inc_up = '0;
   logic [SPEED_BITS-1:0] inc_down = '0;
   logic [STEP_BITS-1:0]  steps_done = '0;
   logic [STEP_BITS-1:0]  steps_goal = '0;
   logic                  dir_now = 1'b0;

   ramp_word_type words_due[$];
   plan_row_type  plan[$];
   int            mismatches = 0;
   int            live_items = 0;
   int            cycles = 0;
   int            rsp_gap = 0;
   bit            idle_on = 1'b1;
   bit            hold_go = 1'b0;
   logic          long_hold = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [SPEED_BITS-1:0] speed_increment(input logic [SPEED_BITS-1:0] ms);
      int unsigned ticks;
      int unsigned inc;
      ticks = ms / 10;
      if (ticks == 0) ticks = 1;
      inc = 0;
      if (cfg_top > cfg_start) inc = (cfg_top - cfg_start) / ticks;
      if (inc == 0) inc = 1;
      return inc[SPEED_BITS-1:0];
   endfunction

   function automatic logic halt_move();
      ramp_ph = PH_IDLE;
      speed_now = '0;
      return 1'b1;
   endfunction

   function automatic logic exit_cruise();
      if (cfg_top >= cfg_start) begin
         ramp_ph = PH_DECEL;
         speed_now = cfg_top;
         return 1'b0;
      end
      return halt_move();
   endfunction

   function automatic logic begin_cruise();
      ramp_ph = PH_CRUISE;
      speed_now = cfg_top;
      if (steps_done >= (steps_goal >> 1)) return exit_cruise();
      return 1'b0;
   endfunction

   function automatic ramp_word_type advance_ramp(input logic [1:0] kind,
                                                  input logic [STEP_BITS-1:0] steps,
                                                  input logic fwd);
      ramp_word_type       w;
      logic                fin;
      logic [SPEED_BITS:0] faster;
      int unsigned         period;
      int unsigned         half;
      fin = 1'b0;
      unique case (kind)
         REQ_START: begin
            steps_goal = steps;
            dir_now = fwd;
            steps_done = '0;
            inc_up = speed_increment(cfg_accel_ms);
            inc_down = speed_increment(cfg_decel_ms);
            if (cfg_start <= cfg_top) begin
               ramp_ph = PH_ACCEL;
               speed_now = cfg_start;
            end else begin
               fin = begin_cruise();
            end
         end
         REQ_TICK: begin
            if (ramp_ph == PH_ACCEL) begin
               faster = {1'b0, speed_now} + {1'b0, inc_up};
               if (steps_done >= (steps_goal >> 1)) fin = begin_cruise();
               else if (faster > {1'b0, cfg_top}) fin = begin_cruise();
               else speed_now = faster[SPEED_BITS-1:0];
            end else if (ramp_ph == PH_DECEL) begin
               if (steps_done >= steps_goal) fin = halt_move();
               else if (inc_down > speed_now || speed_now - inc_down < cfg_start)
                  fin = halt_move();
               else speed_now = speed_now - inc_down;
            end
         end
         REQ_PULSE: begin
            if (ramp_ph != PH_IDLE) begin
               if (steps_done != '1) steps_done = steps_done + 1'b1;
               if (ramp_ph == PH_CRUISE && steps_done >= (steps_goal >> 1))
                  fin = exit_cruise();
            end
         end
         default: ;
      endcase
      period = 0;
      if (ramp_ph != PH_IDLE && speed_now != '0) period = (CORE_CLOCK_HZ / 2) / speed_now;
      half = period / 2;
      w.pulse_on   = (ramp_ph != PH_IDLE);
      w.period     = period[PERIOD_BITS-1:0];
      w.compare    = half[COMPARE_BITS-1:0];
      w.dir_level  = dir_now;
      w.enable_low = (ramp_ph == PH_IDLE);
      w.busy       = (ramp_ph != PH_IDLE);
      w.done       = fin;
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // result side: random stall per word, plus one long hold-off
   always @(posedge clock) begin
      ramp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               $error("rsp word with nothing expected");
               mismatches++;
            end else begin
               want = words_due.pop_front();
               check_field("pulse_on", 32'(want.pulse_on), 32'(rsp_pulse_on));
               check_field("pulse_period", 32'(want.period), 32'(rsp_pulse_period));
               check_field("pulse_compare", 32'(want.compare), 32'(rsp_pulse_compare));
               check_field("dir_level", 32'(want.dir_level), 32'(rsp_dir_level));
               check_field("enable_low", 32'(want.enable_low), 32'(rsp_enable_low));
               check_field("move_busy", 32'(want.busy), 32'(rsp_move_busy));
               check_field("move_done", 32'(want.done), 32'(rsp_move_done));
            end
            rsp_gap = idle_on ? $urandom_range(0, 16) : 0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end
         rsp_stall <= long_hold || (rsp_gap > 0);
      end
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic send_word(input logic [1:0] kind, input logic [STEP_BITS-1:0] steps,
                            input logic fwd, input logic typed, input ramp_word_type fixed);
      int            gap;
      ramp_word_type w;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_move_steps <= steps;
      req_move_forward <= fwd;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_START || ramp_ph != PH_IDLE) live_items++;
      w = advance_ramp(kind, steps, fwd);
      words_due.push_back(typed ? fixed : w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [SPEED_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         CSR_START_SPEED: cfg_start = val;
         CSR_TOP_SPEED:   cfg_top = val;
         CSR_ACCEL_MS:    cfg_accel_ms = val;
         default:         cfg_decel_ms = val;
      endcase
   endtask

   task automatic run_move();
      int                   r;
      int                   left;
      logic [STEP_BITS-1:0] n;
      r = $urandom_range(0, 99);
      if (r < 8) n = STEP_BITS'($urandom_range(0, 1));
      else if (r < 92) n = STEP_BITS'($urandom_range(2, 120));
      else n = STEP_BITS'($urandom());
      send_word(REQ_START, n, 1'($urandom_range(0, 1)), 1'b0, IDLE_WORD);
      left = MOVE_ITEMS;
      while (ramp_ph != PH_IDLE && left > 0) begin
         r = $urandom_range(0, 99);
         if (r < 2)
            send_word(REQ_UNUSED, STEP_BITS'($urandom()), 1'($urandom_range(0, 1)), 1'b0,
                      IDLE_WORD);
         else if (r < 4)
            send_word(REQ_START, STEP_BITS'($urandom_range(0, 120)),
                      1'($urandom_range(0, 1)), 1'b0, IDLE_WORD);
         else if (r < 44)
            send_word(REQ_TICK, STEP_BITS'($urandom()), 1'($urandom_range(0, 1)), 1'b0,
                      IDLE_WORD);
         else
            send_word(REQ_PULSE, STEP_BITS'($urandom()), 1'($urandom_range(0, 1)), 1'b0,
                      IDLE_WORD);
         left--;
      end
      if ($urandom_range(0, 3) == 0)
         send_word(2'($urandom_range(1, 3)), STEP_BITS'($urandom()),
                   1'($urandom_range(0, 1)), 1'b0, IDLE_WORD);
   endtask

   initial begin
      int                    phase_no;
      int                    phase_base;
      int unsigned           s;
      int unsigned           t;
      int unsigned           a;
      int unsigned           d;

      // idle status, then a move at reset speeds
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b1, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'hFFFFFF, 1'b1, 1'b1, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_UNUSED, 24'd0, 1'b0, 1'b1, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_START, 24'd0, 1'b1, 1'b1, RESET_RUN});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b1, DONE_FWD});
      plan.push_back('{ROW_REQ, REQ_START, 24'hFFFFFF, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_UNUSED, 24'hFFFFFF, 1'b1, 1'b0, IDLE_WORD});
      // restart while busy with a one-step move
      plan.push_back('{ROW_REQ, REQ_START, 24'd1, 1'b1, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      // start speed above top speed
      plan.push_back('{ROW_CSR, CSR_START_SPEED, 24'd65535, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_CSR, CSR_TOP_SPEED, 24'd1, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_CSR, CSR_ACCEL_MS, 24'd10, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_CSR, CSR_DECEL_MS, 24'd65535, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_START, 24'd4, 1'b0, 1'b1, SLOW_BWD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'd0, 1'b0, 1'b1, DONE_BWD});
      plan.push_back('{ROW_REQ, REQ_START, 24'd0, 1'b1, 1'b1, DONE_FWD});
      // slowest to fastest in one tick
      plan.push_back('{ROW_CSR, CSR_START_SPEED, 24'd1, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_CSR, CSR_TOP_SPEED, 24'd65535, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_START, 24'd2, 1'b1, 1'b1, SLOW_FWD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b1, FAST_FWD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_PULSE, 24'd0, 1'b0, 1'b0, IDLE_WORD});
      plan.push_back('{ROW_REQ, REQ_TICK, 24'd0, 1'b0, 1'b0, IDLE_WORD});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_reg(plan[i].code, plan[i].value[SPEED_BITS-1:0]);
         end else begin
            send_word(plan[i].code, plan[i].value, plan[i].fwd, plan[i].typed, plan[i].want);
         end
      end

      phase_no = 0;
      while (live_items < TARGET_ITEMS) begin
         drain();
         unique case (phase_no)
            0: begin s = 1; t = 65535; a = 10; d = 10; end
            1: begin s = 65535; t = 1; a = 65535; d = 10; end
            2: begin s = 65535; t = 65535; a = 65535; d = 65535; end
            default: begin
               s = $urandom_range(1, 3000);
               if ($urandom_range(0, 4) == 0) t = $urandom_range(1, s);
               else t = s + $urandom_range(0, 20000);
               if (t > 65535) t = 65535;
               a = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 65535) : $urandom_range(10, 400);
               d = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 65535) : $urandom_range(10, 400);
            end
         endcase
         write_reg(CSR_START_SPEED, s[SPEED_BITS-1:0]);
         write_reg(CSR_TOP_SPEED, t[SPEED_BITS-1:0]);
         write_reg(CSR_ACCEL_MS, a[SPEED_BITS-1:0]);
         write_reg(CSR_DECEL_MS, d[SPEED_BITS-1:0]);
         idle_on = (phase_no % 4) != 2;
         if (phase_no == 3) begin
            idle_on = 1'b0;
            hold_go = 1'b1;
         end
         phase_base = live_items;
         while (live_items - phase_base < PHASE_ITEMS && live_items < TARGET_ITEMS) run_move();
         phase_no++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/stpr_pkg.sv
rtl/stpr_div.sv
rtl/stpr_dp.sv
rtl/stpr_ctrl.sv
rtl/stepper_trapezoid_ramp.sv
test/stepper_trapezoid_ramp_tb.sv
